[sv/kli_pkg.sv]
package kli_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KEY_CNT_W    = 7;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned RAW_W        = 16;
  localparam int unsigned FRAC_W       = 31;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef logic signed [DATA_W-1:0] q16_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COUNT    = 3'd0,
    CFG_COMPRESSED   = 3'd1,
    CFG_VALUE_SCALE  = 3'd2,
    CFG_VALUE_OFFSET = 3'd3,
    CFG_TIME_SCALE   = 3'd4,
    CFG_TIME_OFFSET  = 3'd5
  } cfg_reg_e;

  localparam q16_t SCALE_RST  = 32'sd65536;
  localparam q16_t OFFSET_RST = 32'sd0;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic q16_t sat_q16(input logic signed [63:0] v);
    q16_t r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/kli_key_store.sv]
module kli_key_store #(
  parameter int unsigned MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_KEYS)-1:0]   wr_addr_i,
  input  logic [kli_pkg::DATA_W-1:0]    wr_time_i,
  input  logic [kli_pkg::DATA_W-1:0]    wr_value_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_KEYS)-1:0]   rd_addr_i,
  output logic [kli_pkg::DATA_W-1:0]    rd_time_o,
  output logic [kli_pkg::DATA_W-1:0]    rd_value_o
);
  import kli_pkg::*;

  logic [DATA_W-1:0] time_mem  [MAX_KEYS];
  logic [DATA_W-1:0] value_mem [MAX_KEYS];
  logic [DATA_W-1:0] rd_time_q;
  logic [DATA_W-1:0] rd_value_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i]  <= wr_time_i;
      value_mem[wr_addr_i] <= wr_value_i;
    end
    if (rd_en_i) begin
      rd_time_q  <= time_mem[rd_addr_i];
      rd_value_q <= value_mem[rd_addr_i];
    end
  end

  assign rd_time_o  = rd_time_q;
  assign rd_value_o = rd_value_q;

endmodule

[sv/kli_dequant.sv]
module kli_dequant (
  input  logic                       clk_i,
  input  logic                       compressed_i,
  input  kli_pkg::q16_t              scale_i,
  input  kli_pkg::q16_t              offset_i,
  input  logic [kli_pkg::DATA_W-1:0] word_i,
  output kli_pkg::q16_t              deq_o
);
  import kli_pkg::*;

  logic signed [RAW_W:0]        raw_s;
  logic signed [RAW_W+DATA_W:0] prod_d;
  logic signed [RAW_W+DATA_W:0] prod_q;
  q16_t                         plain_q;
  logic signed [63:0]           sum;
  q16_t                         deq_q;

  assign raw_s  = $signed({1'b0, word_i[RAW_W-1:0]});
  assign prod_d = raw_s * scale_i;
  assign sum    = 64'(prod_q) + 64'(offset_i);

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    plain_q <= word_i;
    deq_q   <= compressed_i ? sat_q16(sum) : plain_q;
  end

  assign deq_o = deq_q;

endmodule

[sv/kli_divider.sv]
module kli_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [kli_pkg::DATA_W-1:0] num_i,
  input  logic [kli_pkg::DATA_W-1:0] den_i,
  output logic                       done_o,
  output logic [kli_pkg::DATA_W-1:0] quot_o
);
  import kli_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_W);
  localparam logic [DATA_W-1:0] FRAC_ONE = DATA_W'({1'b1, {FRAC_W{1'b0}}});

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] den_q;
  logic [DATA_W-1:0] quot_q;
  logic [DATA_W:0]   shifted;
  logic              ge;

  assign shifted = {rem_q[DATA_W-1:0], 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(FRAC_W - 1);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= (num_i >= den_i) ? FRAC_ONE : '0;
    end else if (busy_q) begin
      rem_q  <= ge ? (shifted - {1'b0, den_q}) : shifted;
      quot_q <= {quot_q[DATA_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[sv/keyframe_linear_interpolator.sv]
// A write transfer stores its key when it is accepted, and the block stays ready for the
// next input item. An evaluate transfer delivers its result to the output register, and no
// further input item is taken until that result sits in the output register.
// Each key visited passes through the memory read and the two-stage dequantiser, and an
// interpolated segment also passes through the bit-serial divider. Reset sets the scales to
// 1.0, clears the other configuration and control registers; key memories are undefined.
module keyframe_linear_interpolator #(
  parameter int unsigned MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kli_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kli_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [kli_pkg::SLOT_W-1:0]    key_index_i,
  input  kli_pkg::q16_t                 key_time_i,
  input  kli_pkg::q16_t                 key_value_i,
  input  kli_pkg::q16_t                 query_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kli_pkg::q16_t                 result_value_o
);
  import kli_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_KEYS);
  localparam int unsigned IW      = KEY_CNT_W + 1;
  localparam logic [1:0]  DEQ_LAT = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_START   = 11'b000_0000_0010,
    S_RD_FRST = 11'b000_0000_0100,
    S_RD_LAST = 11'b000_0000_1000,
    S_RD_SRCH = 11'b000_0001_0000,
    S_RD_SEG0 = 11'b000_0010_0000,
    S_RD_SEG1 = 11'b000_0100_0000,
    S_DIV     = 11'b000_1000_0000,
    S_MUL     = 11'b001_0000_0000,
    S_SUM     = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_CNT_W-1:0] key_count_q;
  logic                 compressed_q;
  q16_t                 value_scale_q, value_offset_q, time_scale_q, time_offset_q;

  logic                 in_fire, wr_en, rd_en, out_free;
  logic [KEY_CNT_W-1:0] rd_idx, i_q, i_next, n_eff;
  logic [IW-1:0]        i_ext, n_ext;
  logic                 more_2, more_3, adv, seg_flat, deq_ok;
  logic [1:0]           wait_q;
  logic [DATA_W-1:0]    rd_time, rd_value;
  q16_t                 t_deq, v_deq;
  q16_t                 query_q, t_lo_q, v_lo_q, res_q, result_q;
  logic signed [DATA_W:0] num_w, den_w, delta_w;
  logic [DATA_W-1:0]    delta_mag, mag_q, frac_q, div_quot;
  logic                 neg_q, div_start, div_done, out_valid_q;
  logic [2*DATA_W-1:0]  prod_q;
  logic signed [DATA_W+2:0] v_ext, m_ext, sum_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign wr_en       = in_fire && (mode_i == MODE_WRITE) && (32'(key_index_i) < MAX_KEYS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q    <= '0;
      compressed_q   <= 1'b0;
      value_scale_q  <= SCALE_RST;
      value_offset_q <= OFFSET_RST;
      time_scale_q   <= SCALE_RST;
      time_offset_q  <= OFFSET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_COUNT:    key_count_q    <= cfg_data_i[KEY_CNT_W-1:0];
        CFG_COMPRESSED:   compressed_q   <= cfg_data_i[0];
        CFG_VALUE_SCALE:  value_scale_q  <= cfg_data_i;
        CFG_VALUE_OFFSET: value_offset_q <= cfg_data_i;
        CFG_TIME_SCALE:   time_scale_q   <= cfg_data_i;
        CFG_TIME_OFFSET:  time_offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kli_key_store #(
    .MAX_KEYS(MAX_KEYS)
  ) u_key_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (AW'(key_index_i)),
    .wr_time_i  (key_time_i),
    .wr_value_i (key_value_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (AW'(rd_idx)),
    .rd_time_o  (rd_time),
    .rd_value_o (rd_value)
  );

  kli_dequant u_time_deq (
    .clk_i        (clk_i),
    .compressed_i (compressed_q),
    .scale_i      (time_scale_q),
    .offset_i     (time_offset_q),
    .word_i       (rd_time),
    .deq_o        (t_deq)
  );

  kli_dequant u_value_deq (
    .clk_i        (clk_i),
    .compressed_i (compressed_q),
    .scale_i      (value_scale_q),
    .offset_i     (value_offset_q),
    .word_i       (rd_value),
    .deq_o        (v_deq)
  );

  kli_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w[DATA_W-1:0]),
    .den_i   (den_w[DATA_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign n_eff  = (32'(key_count_q) > MAX_KEYS) ? KEY_CNT_W'(MAX_KEYS) : key_count_q;
  assign i_ext  = {1'b0, i_q};
  assign n_ext  = {1'b0, n_eff};
  assign more_2 = (i_ext + IW'(2)) < n_ext;
  assign more_3 = (i_ext + IW'(3)) < n_ext;
  assign adv    = query_q > t_deq;
  assign i_next = adv ? (i_q + KEY_CNT_W'(1)) : i_q;
  assign deq_ok = (wait_q == 2'd0);

  assign num_w     = (DATA_W+1)'(query_q) - (DATA_W+1)'(t_lo_q);
  assign den_w     = (DATA_W+1)'(t_deq) - (DATA_W+1)'(t_lo_q);
  assign seg_flat  = den_w[DATA_W] || (den_w == '0) || (query_q < t_lo_q);
  assign delta_w   = (DATA_W+1)'(v_deq) - (DATA_W+1)'(v_lo_q);
  assign delta_mag = delta_w[DATA_W] ? DATA_W'(-delta_w) : delta_w[DATA_W-1:0];

  assign v_ext = (DATA_W+3)'(v_lo_q);
  assign m_ext = $signed({2'b00, prod_q[2*DATA_W-1:FRAC_W]});
  assign sum_w = neg_q ? (v_ext - m_ext) : (v_ext + m_ext);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    rd_en     = 1'b0;
    rd_idx    = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (mode_i == MODE_EVAL)) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (n_eff == '0) begin
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_RD_FRST;
        end
      end
      S_RD_FRST: begin
        if (deq_ok) begin
          if ((n_eff == KEY_CNT_W'(1)) || (query_q < t_deq)) begin
            state_d = S_OUT;
          end else begin
            rd_en   = 1'b1;
            rd_idx  = n_eff - KEY_CNT_W'(1);
            state_d = S_RD_LAST;
          end
        end
      end
      S_RD_LAST: begin
        if (deq_ok) begin
          if (query_q >= t_deq) begin
            state_d = S_OUT;
          end else if (more_2) begin
            rd_en   = 1'b1;
            rd_idx  = i_q + KEY_CNT_W'(1);
            state_d = S_RD_SRCH;
          end else begin
            rd_en   = 1'b1;
            rd_idx  = i_q;
            state_d = S_RD_SEG0;
          end
        end
      end
      S_RD_SRCH: begin
        if (deq_ok) begin
          rd_en = 1'b1;
          if (adv && more_3) begin
            rd_idx = i_q + KEY_CNT_W'(2);
          end else begin
            rd_idx  = i_next;
            state_d = S_RD_SEG0;
          end
        end
      end
      S_RD_SEG0: begin
        if (deq_ok) begin
          rd_en   = 1'b1;
          rd_idx  = i_q + KEY_CNT_W'(1);
          state_d = S_RD_SEG1;
        end
      end
      S_RD_SEG1: begin
        if (deq_ok) begin
          if (seg_flat) begin
            state_d = S_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        wait_q <= DEQ_LAT;
      end else if (wait_q != '0) begin
        wait_q <= wait_q - 2'd1;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (mode_i == MODE_EVAL)) begin
      query_q <= query_time_i;
    end
    if ((state_q == S_OUT) && out_free) begin
      result_q <= res_q;
    end
    case (state_q)
      S_START: begin
        i_q   <= '0;
        res_q <= '0;
      end
      S_RD_FRST, S_RD_LAST: begin
        if (deq_ok) begin
          res_q <= v_deq;
        end
      end
      S_RD_SRCH: begin
        if (deq_ok) begin
          i_q <= i_next;
        end
      end
      S_RD_SEG0: begin
        if (deq_ok) begin
          t_lo_q <= t_deq;
          v_lo_q <= v_deq;
        end
      end
      S_RD_SEG1: begin
        if (deq_ok) begin
          res_q <= v_lo_q;
          mag_q <= delta_mag;
          neg_q <= delta_w[DATA_W];
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_q <= div_quot;
        end
      end
      S_MUL: prod_q <= mag_q * frac_q;
      S_SUM: res_q  <= sat_q16(64'(sum_w));
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_en && wr_en))
    else $error("Key memory read and write in the same cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> (state_q == S_DIV))
    else $error("Divider finished outside the divide state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("Result presented without a completed evaluation.");

endmodule
